[rtl/bdq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and codes for the bounded deque unit
// Command and status codes, request and response payload structs.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_SEARCH     = 3'd4;
   localparam logic [2:0] CMD_ERASE      = 3'd5;
   localparam logic [2:0] CMD_CLEAR      = 3'd6;
   localparam logic [2:0] CMD_NONE       = 3'd7;  // spare code, no effect

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;
   localparam logic [1:0] STATUS_FULL  = 2'd3;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] value;
      logic [7:0]         position;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic [8:0]         entry_count;
      logic               is_empty;
   } rsp_type;

endpackage

[rtl/bounded_deque_with_search_erase_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_erase_unit: bounded linked-list deque
// Push/pop at both ends, search, erase at position and clear.
// ----------------------------------------------------------------------------
// Usage: send one command per request on req_ (valid/stall). The unit works
// on one request at a time and returns one response on rsp_ carrying the
// status, the search result and the front, back and count after the command.
// Slots live in three registered-read memories (value, next, prev) that a
// sequencer reads and writes one access per cycle.
// Clear, refused or ignored commands and a push into a never used slot go
// straight to reading front and back; a push into a freed slot and a pop
// add a step, erase at position p also walks p links and relinks an inner
// entry's neighbors, and a search compares entries until a match or the end.
// The next request is accepted in the cycle after the response is registered.
// A finished response waits in an output register; the next request is
// taken while it waits and then holds in its last step, keeping req_stall
// high, until the receiver takes the waiting response.
// Reset clears the list pointers and counters at once; the slot memories
// need no clearing pass since data read from an unwritten slot is unused.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_erase_unit
   import bdq_pkg::*;
#(
   parameter int CAPACITY   = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 8) ? CW : 8;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RDA    = 4'd1;  // read first link
   localparam logic [3:0] ST_UNLNK  = 4'd2;  // link data arrives
   localparam logic [3:0] ST_FIXP   = 4'd3;  // relink both neighbors
   localparam logic [3:0] ST_WALK   = 4'd4;
   localparam logic [3:0] ST_SRCH   = 4'd5;
   localparam logic [3:0] ST_FRONT  = 4'd6;  // read front value
   localparam logic [3:0] ST_BACK   = 4'd7;  // read back value
   localparam logic [3:0] ST_BACKW  = 4'd8;
   localparam logic [3:0] ST_DONE   = 4'd9;
   localparam logic [3:0] ST_FREE   = 4'd10; // next of free head arrives

   logic [3:0]    state_ff, state_in;
   req_type       req_ff, req_in;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in, free_ff, free_in;
   logic [CW-1:0] count_ff, count_in, listed_ff, listed_in, mark_ff, mark_in;
   logic [AW-1:0] cur_ff, cur_in, nb_ff, nb_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [1:0]    status_ff, status_in;
   logic          found_ff, found_in;
   logic [DATA_WIDTH-1:0] fv_ff, fv_in, bv_ff, bv_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, out_in;

   logic                  v_we, n_we, p_we;
   logic [AW-1:0]         v_wa, n_wa, p_wa, v_ra, n_ra, p_ra;
   logic [DATA_WIDTH-1:0] v_wd, v_rd, key;
   logic [AW-1:0]         n_wd, p_wd, n_rd, p_rd;
   logic [AW-1:0]         new_slot;
   logic                  take;

   bdq_slot_mem #(.DEPTH(CAPACITY), .AW(AW), .DW(DATA_WIDTH)) u_value (
      .clock, .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(v_ra), .rd_data(v_rd));
   bdq_slot_mem #(.DEPTH(CAPACITY), .AW(AW), .DW(AW)) u_next (
      .clock, .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd),
      .rd_addr(n_ra), .rd_data(n_rd));
   bdq_slot_mem #(.DEPTH(CAPACITY), .AW(AW), .DW(AW)) u_prev (
      .clock, .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));

   assign key       = DATA_WIDTH'(req_ff.value);
   assign new_slot  = (listed_ff != '0) ? free_ff : mark_ff[AW-1:0];
   assign take      = req_valid && state_ff == ST_IDLE;
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // sequencer
   always_comb begin
      state_in = state_ff; req_in = req_ff;
      head_in = head_ff; tail_in = tail_ff; free_in = free_ff;
      count_in = count_ff; listed_in = listed_ff; mark_in = mark_ff;
      cur_in = cur_ff; nb_in = nb_ff; idx_in = idx_ff;
      status_in = status_ff; found_in = found_ff; fv_in = fv_ff; bv_in = bv_ff;
      out_valid_in = out_valid_ff && rsp_stall; out_in = out_ff;
      v_we = 1'b0; n_we = 1'b0; p_we = 1'b0;
      v_wa = new_slot; n_wa = new_slot; p_wa = new_slot;
      v_wd = key; n_wd = head_ff; p_wd = tail_ff;
      v_ra = head_ff; n_ra = cur_ff; p_ra = cur_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               req_in = req_data; status_in = STATUS_DONE; found_in = 1'b0;
               cur_in = head_ff; idx_in = '0;
               state_in = ST_RDA;
            end
         end
         ST_RDA: begin
            // decode and do the first access
            state_in = ST_FRONT;
            unique case (req_ff.cmd) inside
               CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     v_we = 1'b1;
                     if (count_ff != '0) begin
                        if (req_ff.cmd == CMD_PUSH_FRONT) begin
                           n_we = 1'b1; p_we = 1'b1; p_wa = head_ff;
                           p_wd = new_slot; head_in = new_slot;
                        end else begin
                           p_we = 1'b1; n_we = 1'b1; n_wa = tail_ff;
                           n_wd = new_slot; tail_in = new_slot;
                        end
                     end else begin
                        head_in = new_slot; tail_in = new_slot;
                     end
                     count_in = count_ff + 1'b1;
                     if (listed_ff != '0) begin
                        listed_in = listed_ff - 1'b1;
                        n_ra = free_ff; cur_in = free_ff;
                        state_in = ST_FREE;
                     end else begin
                        mark_in = mark_ff + 1'b1;
                     end
                  end
               end
               CMD_POP_FRONT, CMD_POP_BACK: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     cur_in = (req_ff.cmd == CMD_POP_FRONT) ? head_ff : tail_ff;
                     n_ra = cur_in; p_ra = cur_in;
                     state_in = ST_UNLNK;
                  end
               end
               CMD_SEARCH: begin
                  if (count_ff != '0) begin
                     v_ra = head_ff; n_ra = head_ff;
                     state_in = ST_SRCH;
                  end
               end
               CMD_ERASE: begin
                  if (PW'(req_ff.position) >= PW'(count_ff)) begin
                     status_in = STATUS_RANGE;
                  end else if (req_ff.position == '0) begin
                     n_ra = head_ff; p_ra = head_ff; cur_in = head_ff;
                     state_in = ST_UNLNK;
                  end else begin
                     n_ra = head_ff; idx_in = CW'(1);
                     state_in = ST_WALK;
                  end
               end
               CMD_CLEAR: begin
                  count_in = '0; listed_in = '0; mark_in = '0;
                  free_in = '0; head_in = '0; tail_in = '0;
               end
               default: ;
            endcase
         end
         ST_FREE: begin
            // advance the free list past the taken slot
            free_in = n_rd;
            state_in = ST_FRONT;
         end
         ST_WALK: begin
            // follow next links, one per cycle
            if (idx_ff == CW'(req_ff.position)) begin
               cur_in = n_rd; n_ra = n_rd; p_ra = n_rd;
               state_in = ST_UNLNK;
            end else begin
               n_ra = n_rd; idx_in = idx_ff + 1'b1;
            end
         end
         ST_SRCH: begin
            if (v_rd == key) begin
               found_in = 1'b1; state_in = ST_FRONT;
            end else if (idx_ff + 1'b1 == count_ff) begin
               state_in = ST_FRONT;
            end else begin
               v_ra = n_rd; n_ra = n_rd; idx_in = idx_ff + 1'b1;
            end
         end
         ST_UNLNK: begin
            // splice out cur, return it to the free list
            n_we = 1'b1; n_wa = cur_ff; n_wd = free_ff;
            free_in = cur_ff; listed_in = listed_ff + 1'b1;
            state_in = ST_FRONT;
            if (count_ff == CW'(1)) begin
               count_in = '0;
            end else begin
               count_in = count_ff - 1'b1;
               if (cur_ff == head_ff) begin
                  head_in = n_rd;
               end else if (cur_ff == tail_ff) begin
                  tail_in = p_rd;
               end else begin
                  nb_in = n_rd; cur_in = p_rd;
                  state_in = ST_FIXP;
               end
            end
         end
         ST_FIXP: begin
            // link the neighbors of the erased slot to each other
            p_we = 1'b1; p_wa = nb_ff; p_wd = cur_ff;
            n_we = 1'b1; n_wa = cur_ff; n_wd = nb_ff;
            state_in = ST_FRONT;
         end
         ST_FRONT: begin
            v_ra = head_ff; state_in = ST_BACK;
         end
         ST_BACK: begin
            v_ra = tail_ff; fv_in = v_rd; state_in = ST_BACKW;
         end
         ST_BACKW: begin
            bv_in = v_rd; state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               out_in.status = status_ff;
               out_in.found = found_ff;
               out_in.entry_count = 9'(count_ff);
               out_in.is_empty = count_ff == '0;
               out_in.front_value = (count_ff == '0) ? '0 : 32'(signed'(fv_ff));
               out_in.back_value = (count_ff == '0) ? '0 : 32'(signed'(bv_ff));
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; out_valid_ff <= 1'b0;
         head_ff <= '0; tail_ff <= '0; free_ff <= '0;
         count_ff <= '0; listed_ff <= '0; mark_ff <= '0;
      end else begin
         state_ff <= state_in; out_valid_ff <= out_valid_in;
         head_ff <= head_in; tail_ff <= tail_in; free_ff <= free_in;
         count_ff <= count_in; listed_ff <= listed_in; mark_ff <= mark_in;
      end
      req_ff <= req_in; cur_ff <= cur_in; nb_ff <= nb_in; idx_ff <= idx_in;
      status_ff <= status_in; found_ff <= found_in; fv_ff <= fv_in; bv_ff <= bv_in;
      out_ff <= out_in;
   end

endmodule

[rtl/bdq_slot_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_slot_mem: slot storage (value, next, prev)
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bdq_slot_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];

   // write one entry, read one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the bounded deque unit
// Drives pushes, pops, searches, erases and clears with random gaps on both
// channels, predicts each response with a software copy of the list and
// checks the responses in order, field by field.
// ----------------------------------------------------------------------------

class deque_scoreboard;
   int           held[$];
   bdq_pkg::rsp_type pending[$];
   int           mismatches;

   // Apply one request to the list copy and queue the response it causes.
   function void note_request(bdq_pkg::req_type r);
      bdq_pkg::rsp_type e;
      e = '0;
      case (r.cmd) inside
         bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
            if (held.size() >= 256) e.status = bdq_pkg::STATUS_FULL;
            else if (r.cmd == bdq_pkg::CMD_PUSH_FRONT) held.insert(0, r.value);
            else held.insert(held.size(), r.value);
         end
         bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK: begin
            if (held.size() == 0) e.status = bdq_pkg::STATUS_EMPTY;
            else if (r.cmd == bdq_pkg::CMD_POP_FRONT) held.delete(0);
            else held.delete(held.size() - 1);
         end
         bdq_pkg::CMD_SEARCH: begin
            foreach (held[i]) if (held[i] == r.value) e.found = 1'b1;
         end
         bdq_pkg::CMD_ERASE: begin
            if (r.position >= held.size()) e.status = bdq_pkg::STATUS_RANGE;
            else held.delete(r.position);
         end
         bdq_pkg::CMD_CLEAR: held.delete();
         default: ;
      endcase
      if (held.size() > 0) begin
         e.front_value = held[0];
         e.back_value  = held[held.size() - 1];
      end
      e.entry_count = 9'(held.size());
      e.is_empty    = held.size() == 0;
      pending.insert(pending.size(), e);
   endfunction

   // Compare one response against the oldest prediction.
   function void check_response(bdq_pkg::rsp_type a);
      bdq_pkg::rsp_type e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response %h", a);
         return;
      end
      e = pending[0];
      pending.delete(0);
      if (a.status !== e.status || a.found !== e.found || a.front_value !== e.front_value
          || a.back_value !== e.back_value || a.entry_count !== e.entry_count
          || a.is_empty !== e.is_empty) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch: exp st=%0d f=%0d fr=%0d bk=%0d n=%0d e=%0d,",
                      " got st=%0d f=%0d fr=%0d bk=%0d n=%0d e=%0d"},
                     e.status, e.found, e.front_value, e.back_value, e.entry_count,
                     e.is_empty, a.status, a.found, a.front_value, a.back_value,
                     a.entry_count, a.is_empty);
      end
   endfunction
endclass

module tb;
   import bdq_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   deque_scoreboard board = new();
   int  send_idle_pct = 36;
   int  recv_idle_pct = 54;
   bit  hold_off = 1'b0;
   int  quiet_cycles = 0;

   always #6 clock = ~clock;

   bounded_deque_with_search_erase_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Note accepted requests, check accepted responses, watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_request(req_data);
         if (rsp_valid && !rsp_stall) board.check_response(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 20000) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // Stall the response channel at random, or hold off entirely on request.
   always @(negedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
   end

   // Offer one request and hold it until accepted; valid stays high after.
   task automatic send_request(logic [2:0] c, logic [31:0] v, logic [7:0] p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{cmd: c, value: v, position: p};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom_range(7);
         1: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
         default: return $urandom();
      endcase
   endfunction

   // Mostly pushes and pops around a busy list, with searches, erases, clears and the spare code.
   task automatic random_request();
      int k;
      int n;
      k = $urandom_range(99);
      n = board.held.size();
      if (k < 30) send_request(3'(CMD_PUSH_BACK - $urandom_range(1)), pick_value(), 8'd0);
      else if (k < 50) send_request(3'(CMD_POP_FRONT + $urandom_range(1)), $urandom(), 8'd0);
      else if (k < 68) send_request(CMD_SEARCH, (n > 0 && $urandom_range(1))
                                    ? board.held[$urandom_range(n - 1)] : pick_value(), 8'd0);
      else if (k < 92) send_request(CMD_ERASE, $urandom(),
                                    8'((n > 0 && $urandom_range(3) != 0) ? $urandom_range(n - 1)
                                                                         : $urandom_range(255)));
      else if (k < 94) send_request(CMD_CLEAR, $urandom(), 8'($urandom()));
      else if (k < 96) send_request(CMD_NONE, $urandom(), 8'($urandom()));
      else send_request(CMD_PUSH_FRONT, pick_value(), 8'($urandom()));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty cases, both ends, search, erase extremes, odd code.
      send_request(CMD_POP_FRONT, 0, 0);
      send_request(CMD_POP_BACK, 0, 0);
      send_request(CMD_ERASE, 0, 0);
      send_request(CMD_SEARCH, 0, 0);
      send_request(CMD_PUSH_FRONT, 32'h7fff_ffff, 8'hff);
      send_request(CMD_PUSH_BACK, 32'h8000_0000, 0);
      send_request(CMD_PUSH_FRONT, 32'hffff_ffff, 0);
      send_request(CMD_SEARCH, 32'h8000_0000, 0);
      send_request(CMD_SEARCH, 32'h1234_5678, 0);
      send_request(CMD_ERASE, 0, 8'd1);
      send_request(CMD_ERASE, 0, 8'd2);
      send_request(CMD_ERASE, 0, 8'd255);
      send_request(CMD_NONE, 32'hdead_beef, 8'haa);
      send_request(CMD_POP_BACK, 0, 0);
      send_request(CMD_POP_FRONT, 0, 0);
      send_request(CMD_CLEAR, 0, 0);

      // Fill to capacity with the receiver held off at first, then overflow.
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 258; i++) send_request(CMD_PUSH_BACK, $urandom(), 0);
      join
      send_request(CMD_PUSH_FRONT, 1, 0);
      send_request(CMD_SEARCH, board.held[255], 0);
      send_request(CMD_ERASE, 0, 8'd255);
      send_request(CMD_ERASE, 0, 8'd128);
      send_request(CMD_CLEAR, 0, 0);

      // Random phases with changing idle rates.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 54 : 0;
         recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 36 : 0;
         for (int i = 0; i < 340; i++) random_request();
      end
      req_valid <= 1'b0;

      while (board.pending.size() > 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end
endmodule
